@@ src/indexed_event_queue_unit_assert.svh @@
// Assertion shorthands shared by the queue modules.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef INDEXED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_EVENT_QUEUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IEQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ieq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ieq assertion failed");

`endif

@@ src/ieq_pkg.sv @@
package ieq_pkg;

    localparam int LINK_W       = 8;
    localparam int TAG_W        = 8;
    localparam int HANDLE_LIMIT = 256;

    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_SCHEDULE = 2'd1;
    localparam logic [1:0] REQ_CANCEL   = 2'd2;
    localparam logic [1:0] REQ_POP      = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_NOCHANGE  = 3'd4;

    typedef struct packed {
        logic accept;
        logic finish;
    } ieq_cmd_t;

    typedef struct packed {
        logic two_step;
    } ieq_sts_t;

endpackage

@@ src/indexed_event_queue_unit.sv @@
// Indexed event queue: a pool of event slots with the pending ones kept in
// FIFO order as a doubly linked list (slot 0 is the null link).
// Request channel (in_valid/in_ready): req_type, slot_handle, slot_tag.
//   alloc hands out the next slot and stores its tag, schedule appends a
//   slot, cancel unlinks a pending slot, pop removes the head.
// Result channel (out_valid/out_ready): out_handle, out_tag, status and
//   pending_count, exactly one result per request, in request order.
// Timing: alloc, schedule and any rejected request load their result when
//   accepted; cancel and a pop of a non-empty queue do the registered read
//   of the link and tag RAMs first, then rewrite the neighbor links and load
//   the result in a finish state. One request is in work at a time; a request
//   can be accepted in the same cycle its predecessor's result is taken.
// A result waits in the output register while out_ready is low; a further
//   request is held off only until that result is taken.
// Reset clears all pending flags, head, tail and count and restarts slot
//   allocation at 1; it takes effect at once with no clearing pass.
module indexed_event_queue_unit #(
    parameter int SLOT_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] slot_handle,
    input  logic [7:0] slot_tag,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_handle,
    output logic [7:0] out_tag,
    output logic [2:0] status,
    output logic [7:0] pending_count
);

    import ieq_pkg::*;

    ieq_cmd_t cmd;
    ieq_sts_t sts;

    ieq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ieq_datapath #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .slot_handle  (slot_handle),
        .slot_tag     (slot_tag),
        .out_handle   (out_handle),
        .out_tag      (out_tag),
        .status       (status),
        .pending_count(pending_count)
    );

endmodule

@@ src/ieq_ram.sv @@
module ieq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ieq_ctrl.sv @@
`include "indexed_event_queue_unit_assert.svh"

module ieq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ieq_pkg::ieq_sts_t sts,
    output ieq_pkg::ieq_cmd_t cmd
);

    import ieq_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_FINISH = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.accept = accept;
    assign cmd.finish = (state_reg == S_FINISH);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.two_step)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `IEQ_ASSERT_NEXT(a_finish_delivers, (state_reg == S_FINISH),
                     (state_reg == S_IDLE) && out_valid_reg)
    `IEQ_ASSERT_NEXT(a_short_delivers, accept && !sts.two_step, out_valid_reg)
    `IEQ_ASSERT_IMPL(a_finish_out_free, (state_reg == S_FINISH), !out_valid_reg)

endmodule

@@ src/ieq_datapath.sv @@
`include "indexed_event_queue_unit_assert.svh"

module ieq_datapath #(
    parameter int SLOT_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ieq_pkg::ieq_cmd_t cmd,
    output ieq_pkg::ieq_sts_t sts,
    input  logic [1:0]        req_type,
    input  logic [7:0]        slot_handle,
    input  logic [7:0]        slot_tag,
    output logic [7:0]        out_handle,
    output logic [7:0]        out_tag,
    output logic [2:0]        status,
    output logic [7:0]        pending_count
);

    import ieq_pkg::*;

    localparam int DEPTH = (SLOT_COUNT < HANDLE_LIMIT) ? SLOT_COUNT : HANDLE_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(DEPTH);

    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [7:0]        count_reg, count_next;
    logic [8:0]        free_reg, free_next;
    logic [DEPTH-1:0]  pend_reg, pend_next;
    logic [1:0]        req_reg, req_next;
    logic [LINK_W-1:0] slot_reg, slot_next;

    logic [7:0] out_handle_reg, out_tag_reg, pending_count_reg;
    logic [2:0] status_reg;
    logic       load_out;
    logic [7:0] oh, ot;
    logic [2:0] st;

    logic [AW-1:0] h_idx, head_idx, tail_idx, s_idx, raddr;
    logic          h_ok, h_pend, count_zero, free_ok;

    logic              next_we, prev_we, tag_we;
    logic [AW-1:0]     next_waddr, prev_waddr, tag_waddr;
    logic [LINK_W-1:0] next_wdata, prev_wdata;
    logic [LINK_W-1:0] nx, pv;
    logic [TAG_W-1:0]  tag_rdata;

    assign h_idx      = slot_handle[AW-1:0];
    assign head_idx   = head_reg[AW-1:0];
    assign tail_idx   = tail_reg[AW-1:0];
    assign s_idx      = slot_reg[AW-1:0];
    assign h_ok       = (slot_handle != '0) && ({1'b0, slot_handle} < DEPTH_LIM);
    assign h_pend     = h_ok ? pend_reg[h_idx] : 1'b0;
    assign count_zero = (count_reg == '0);
    assign free_ok    = (free_reg < DEPTH_LIM);
    assign raddr      = (req_type == REQ_POP) ? head_idx : h_idx;

    assign sts.two_step = ((req_type == REQ_CANCEL) && h_pend)
                       || ((req_type == REQ_POP) && !count_zero);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        free_next  = free_reg;
        pend_next  = pend_reg;
        req_next   = req_reg;
        slot_next  = slot_reg;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        tag_we     = 1'b0;
        next_waddr = tail_idx;
        prev_waddr = h_idx;
        tag_waddr  = free_reg[AW-1:0];
        next_wdata = slot_handle;
        prev_wdata = tail_reg;
        load_out   = 1'b0;
        oh         = '0;
        ot         = '0;
        st         = ST_DONE;

        if (cmd.accept)
        begin
            req_next = req_type;
            case (req_type)
                REQ_ALLOC:
                begin
                    load_out = 1'b1;
                    if (free_ok)
                    begin
                        tag_we    = 1'b1;
                        free_next = free_reg + 9'd1;
                        oh        = free_reg[7:0];
                    end
                    else
                    begin
                        st = ST_EXHAUSTED;
                    end
                end
                REQ_SCHEDULE:
                begin
                    load_out = 1'b1;
                    if (!h_ok)
                    begin
                        st = ST_INVALID;
                    end
                    else if (h_pend)
                    begin
                        st = ST_NOCHANGE;
                    end
                    else
                    begin
                        // Link after the old tail; the new tail's next link is
                        // written only when something is appended behind it.
                        if (count_zero)
                        begin
                            head_next = slot_handle;
                        end
                        else
                        begin
                            next_we = 1'b1;
                        end
                        prev_we          = 1'b1;
                        tail_next        = slot_handle;
                        pend_next[h_idx] = 1'b1;
                        count_next       = count_reg + 8'd1;
                    end
                end
                REQ_CANCEL:
                begin
                    slot_next = slot_handle;
                    if (!h_ok)
                    begin
                        load_out = 1'b1;
                        st       = ST_INVALID;
                    end
                    else if (!h_pend)
                    begin
                        load_out = 1'b1;
                        st       = ST_NOCHANGE;
                    end
                end
                REQ_POP:
                begin
                    slot_next = head_reg;
                    if (count_zero)
                    begin
                        load_out = 1'b1;
                        st       = ST_EMPTY;
                    end
                end
                default:
                begin
                    load_out = 1'b1;
                end
            endcase
        end
        else if (cmd.finish)
        begin
            // Unlink slot_reg using the links read in the accept cycle.
            load_out = 1'b1;
            if ((head_reg == slot_reg) && (tail_reg == slot_reg))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else if (head_reg == slot_reg)
            begin
                head_next = nx;
            end
            else if (tail_reg == slot_reg)
            begin
                tail_next = pv;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = pv[AW-1:0];
                next_wdata = nx;
                prev_we    = 1'b1;
                prev_waddr = nx[AW-1:0];
                prev_wdata = pv;
            end
            pend_next[s_idx] = 1'b0;
            count_next       = count_reg - 8'd1;
            if (req_reg == REQ_POP)
            begin
                oh = slot_reg;
                ot = tag_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            free_reg  <= 9'd1;
            pend_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        if (load_out)
        begin
            out_handle_reg    <= oh;
            out_tag_reg       <= ot;
            status_reg        <= st;
            pending_count_reg <= count_next;
        end
    end

    assign out_handle    = out_handle_reg;
    assign out_tag       = out_tag_reg;
    assign status        = status_reg;
    assign pending_count = pending_count_reg;

    ieq_ram #(
        .WIDTH(LINK_W),
        .DEPTH(DEPTH)
    ) u_next_ram (
        .clk  (clk),
        .we   (next_we),
        .waddr(next_waddr),
        .wdata(next_wdata),
        .raddr(raddr),
        .rdata(nx)
    );

    ieq_ram #(
        .WIDTH(LINK_W),
        .DEPTH(DEPTH)
    ) u_prev_ram (
        .clk  (clk),
        .we   (prev_we),
        .waddr(prev_waddr),
        .wdata(prev_wdata),
        .raddr(raddr),
        .rdata(pv)
    );

    ieq_ram #(
        .WIDTH(TAG_W),
        .DEPTH(DEPTH)
    ) u_tag_ram (
        .clk  (clk),
        .we   (tag_we),
        .waddr(tag_waddr),
        .wdata(slot_tag),
        .raddr(raddr),
        .rdata(tag_rdata)
    );

    `IEQ_ASSERT_IMPL(a_empty_no_links, count_zero, (head_reg == '0) && (tail_reg == '0))
    `IEQ_ASSERT_IMPL(a_head_pending, !count_zero, pend_reg[head_idx] && pend_reg[tail_idx])
    `IEQ_ASSERT_NEXT(a_finish_drops_one, cmd.finish, !pend_reg[$past(s_idx)])

endmodule
